// File: src/vthc_pkg.sv
// Shared widths, register indexes and reset values for the voxel hit counter.
// No dependencies; vthc_out_if and the top level refer to this package by scope.
package vthc_pkg;

  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W     = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

  localparam logic [CFG_W-1:0] SIZE_RESET = 6'd32;

  // Offset code per axis for the neighbor walk: minus one, same, plus one
  localparam logic [1:0] OFS_NEG  = 2'd0;
  localparam logic [1:0] OFS_ZERO = 2'd1;
  localparam logic [1:0] OFS_POS  = 2'd2;

endpackage

// File: src/vthc_in_if.sv
// Input voxel channel: valid/ready handshake with prediction, truth and batch end.
// Depends on nothing but itself.
interface vthc_in_if;
  logic valid;
  logic ready;
  logic pred_bit;
  logic truth_bit;
  logic batch_end;

  modport source (output valid, output pred_bit, output truth_bit, output batch_end,
                  input ready);
  modport sink   (input valid, input pred_bit, input truth_bit, input batch_end,
                  output ready);
endinterface

// File: src/vthc_out_if.sv
// Result channel: valid/ready handshake carrying the batch hit count.
// Depends on vthc_pkg for the count width.
interface vthc_out_if;
  logic                       valid;
  logic                       ready;
  logic [vthc_pkg::CNT_W-1:0] hit_count;

  modport source (output valid, output hit_count, input ready);
  modport sink   (input valid, input hit_count, output ready);
endinterface

// File: src/vthc_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No package dependencies.
module vthc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 32768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/voxel_tolerant_hit_counter_unit.sv
// Voxel hit counter: top level with the load sequencer and the neighborhood scan.
// Depends on vthc_pkg, vthc_in_if, vthc_out_if and vthc_ram.
//
// Usage: voxels enter on in_i in raster order (x fastest, then y, then z), one
// item per voxel with a prediction and a truth bit. Volume extents come from
// three size registers on the cfg port (reset 32; zero acts as one, values above
// MAX_DIM act as MAX_DIM); a size write restarts the current volume.
// Flow: a voxel that does not close a volume is written to the store when it is
// accepted, and the next item is taken in the next cycle. The item that closes a
// volume, or carries batch_end, starts a scan over the received voxels through
// the single read port of the voxel store: each one is read and checked; for each
// truth voxel the walk reads each neighbor in the volume and received, and skips
// the others (27 neighbors at most, the walk stops at the first prediction found);
// the scan ends in ST_FIN, through a last ST_C_RD when batch_end cuts the volume
// short. in_i.ready is low for the whole scan.
// At batch_end the saturating total appears on out_o and the total clears. The
// result register holds the count until it is taken; if a stalled result is
// still waiting when the next batch ends, the block holds in its finish state.
// Reset clears the position, the total and the result valid; the voxel store
// needs no clearing since only voxels of the current volume are read.
module voxel_tolerant_hit_counter_unit #(
  parameter int MAX_DIM = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [vthc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [vthc_pkg::CFG_W-1:0]     cfg_data_i,
  vthc_in_if.sink                        in_i,
  vthc_out_if.source                     out_o
);

  localparam int CW = $clog2(MAX_DIM);
  localparam int AW = 3 * CW;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_C_RD  = 6'b000010,
    ST_C_CHK = 6'b000100,
    ST_N_RD  = 6'b001000,
    ST_N_CHK = 6'b010000,
    ST_FIN   = 6'b100000
  } state_e;

  typedef struct packed {
    logic [CW-1:0] z;
    logic [CW-1:0] y;
    logic [CW-1:0] x;
  } coord_t;

  function automatic logic [CW-1:0] size_lim(logic [vthc_pkg::CFG_W-1:0] r);
    int v;
    v = int'(r);
    if (v == 0) begin
      v = 1;
    end else if (v > MAX_DIM) begin
      v = MAX_DIM;
    end
    return CW'(v - 1);
  endfunction

  // Raster order compare: a at or before b
  function automatic logic not_after(coord_t a, coord_t b);
    return (a.z < b.z) || ((a.z == b.z) && ((a.y < b.y) || ((a.y == b.y) && (a.x <= b.x))));
  endfunction

  state_e state_q, state_d;
  logic [vthc_pkg::CFG_W-1:0] size_x_q, size_y_q, size_z_q;
  coord_t lim, pos_q, pos_d, last_q, last_d, cur_q, cur_d, cur_nx, nb;
  logic [1:0] dx_q, dx_d, dy_q, dy_d, dz_q, dz_d;
  logic batch_q, batch_d;
  logic [vthc_pkg::CNT_W-1:0] total_q, total_d, out_q, out_d;
  logic out_valid_q, out_valid_d;
  logic in_acc, cfg_hit, vol_end, cur_last, d_last, nb_ok, x_ok, y_ok, z_ok;
  logic [CW:0] nx_ext, ny_ext, nz_ext;
  logic ram_re;
  logic [AW-1:0] ram_raddr;
  logic [1:0] ram_rdata;

  assign lim.x = size_lim(size_x_q);
  assign lim.y = size_lim(size_y_q);
  assign lim.z = size_lim(size_z_q);

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign cfg_hit    = cfg_we_i && ((cfg_idx_i == vthc_pkg::REG_SIZE_X) ||
                                   (cfg_idx_i == vthc_pkg::REG_SIZE_Y) ||
                                   (cfg_idx_i == vthc_pkg::REG_SIZE_Z));
  assign vol_end    = (pos_q.x == lim.x) && (pos_q.y == lim.y) && (pos_q.z == lim.z);

  // Scan position step in raster order
  assign cur_last = (cur_q.x == lim.x) && (cur_q.y == lim.y) && (cur_q.z == lim.z);
  always_comb begin
    cur_nx = cur_q;
    if (cur_q.x != lim.x) begin
      cur_nx.x = cur_q.x + 1'b1;
    end else begin
      cur_nx.x = '0;
      if (cur_q.y != lim.y) begin
        cur_nx.y = cur_q.y + 1'b1;
      end else begin
        cur_nx.y = '0;
        cur_nx.z = cur_q.z + 1'b1;
      end
    end
  end

  // Neighbor address and whether it lies in the volume and was received
  assign nx_ext = {1'b0, cur_q.x} + (CW+1)'(dx_q) - (CW+1)'(1);
  assign ny_ext = {1'b0, cur_q.y} + (CW+1)'(dy_q) - (CW+1)'(1);
  assign nz_ext = {1'b0, cur_q.z} + (CW+1)'(dz_q) - (CW+1)'(1);
  assign nb.x   = nx_ext[CW-1:0];
  assign nb.y   = ny_ext[CW-1:0];
  assign nb.z   = nz_ext[CW-1:0];
  assign x_ok   = !((dx_q == vthc_pkg::OFS_NEG) && (cur_q.x == '0)) &&
                  !((dx_q == vthc_pkg::OFS_POS) && (cur_q.x == lim.x));
  assign y_ok   = !((dy_q == vthc_pkg::OFS_NEG) && (cur_q.y == '0)) &&
                  !((dy_q == vthc_pkg::OFS_POS) && (cur_q.y == lim.y));
  assign z_ok   = !((dz_q == vthc_pkg::OFS_NEG) && (cur_q.z == '0)) &&
                  !((dz_q == vthc_pkg::OFS_POS) && (cur_q.z == lim.z));
  assign nb_ok  = x_ok && y_ok && z_ok && not_after(nb, last_q);
  assign d_last = (dx_q == vthc_pkg::OFS_POS) && (dy_q == vthc_pkg::OFS_POS) &&
                  (dz_q == vthc_pkg::OFS_POS);

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    last_d      = last_q;
    cur_d       = cur_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    dz_d        = dz_q;
    batch_d     = batch_q;
    total_d     = total_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    ram_re      = 1'b0;
    ram_raddr   = cur_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (vol_end || in_i.batch_end) begin
            last_d  = pos_q;
            batch_d = in_i.batch_end;
            cur_d   = '0;
            pos_d   = '0;
            state_d = ST_C_RD;
          end else if (pos_q.x != lim.x) begin
            pos_d.x = pos_q.x + 1'b1;
          end else begin
            pos_d.x = '0;
            if (pos_q.y != lim.y) begin
              pos_d.y = pos_q.y + 1'b1;
            end else begin
              pos_d.y = '0;
              pos_d.z = pos_q.z + 1'b1;
            end
          end
        end
      end
      ST_C_RD: begin
        if (not_after(cur_q, last_q)) begin
          ram_re  = 1'b1;
          state_d = ST_C_CHK;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_C_CHK: begin
        if (ram_rdata[1]) begin
          dx_d    = vthc_pkg::OFS_NEG;
          dy_d    = vthc_pkg::OFS_NEG;
          dz_d    = vthc_pkg::OFS_NEG;
          state_d = ST_N_RD;
        end else begin
          cur_d   = cur_nx;
          state_d = cur_last ? ST_FIN : ST_C_RD;
        end
      end
      ST_N_RD: begin
        if (nb_ok) begin
          ram_re    = 1'b1;
          ram_raddr = nb;
          state_d   = ST_N_CHK;
        end else if (d_last) begin
          cur_d   = cur_nx;
          state_d = cur_last ? ST_FIN : ST_C_RD;
        end else begin
          if (dx_q != vthc_pkg::OFS_POS) begin
            dx_d = dx_q + 1'b1;
          end else begin
            dx_d = vthc_pkg::OFS_NEG;
            if (dy_q != vthc_pkg::OFS_POS) begin
              dy_d = dy_q + 1'b1;
            end else begin
              dy_d = vthc_pkg::OFS_NEG;
              dz_d = dz_q + 1'b1;
            end
          end
        end
      end
      ST_N_CHK: begin
        if (ram_rdata[0] || d_last) begin
          // Found a prediction, or no neighbor left: move to the next voxel
          if (ram_rdata[0] && (total_q != '1)) begin
            total_d = total_q + 1'b1;
          end
          cur_d   = cur_nx;
          state_d = cur_last ? ST_FIN : ST_C_RD;
        end else begin
          state_d = ST_N_RD;
          if (dx_q != vthc_pkg::OFS_POS) begin
            dx_d = dx_q + 1'b1;
          end else begin
            dx_d = vthc_pkg::OFS_NEG;
            if (dy_q != vthc_pkg::OFS_POS) begin
              dy_d = dy_q + 1'b1;
            end else begin
              dy_d = vthc_pkg::OFS_NEG;
              dz_d = dz_q + 1'b1;
            end
          end
        end
      end
      ST_FIN: begin
        if (!batch_q) begin
          state_d = ST_IDLE;
        end else if (!out_valid_q || out_o.ready) begin
          // Hold here while an earlier result is still stalled
          out_d       = total_q;
          out_valid_d = 1'b1;
          total_d     = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_hit) begin
      pos_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      size_x_q    <= vthc_pkg::SIZE_RESET;
      size_y_q    <= vthc_pkg::SIZE_RESET;
      size_z_q    <= vthc_pkg::SIZE_RESET;
      pos_q       <= '0;
      batch_q     <= 1'b0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      batch_q     <= batch_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          vthc_pkg::REG_SIZE_X: size_x_q <= cfg_data_i;
          vthc_pkg::REG_SIZE_Y: size_y_q <= cfg_data_i;
          vthc_pkg::REG_SIZE_Z: size_z_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    cur_q  <= cur_d;
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    dz_q   <= dz_d;
    out_q  <= out_d;
  end

  vthc_ram #(
    .WIDTH (2),
    .DEPTH (2 ** AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (pos_q),
    .wdata_i ({in_i.truth_bit, in_i.pred_bit}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_o.valid     = out_valid_q;
  assign out_o.hit_count = out_q;

endmodule
